// File: sv/pfa_pkg.sv
// Shared types and constants for the prime field arithmetic unit.
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int FIELD_WIDTH = 40;
  localparam logic [63:0] MODULUS_RESET = 64'd1071482619497;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_DISP,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_EU_CHK,
    ST_DIV_SHF,
    ST_DIV_ACC,
    ST_EU_UPD,
    ST_OUT
  } state_t;

endpackage

// File: sv/pfa_queue.sv
// Front end: accepts input beats and holds them in a short queue for the core.
`timescale 1ns / 1ps
module pfa_queue #(
  parameter int W = pfa_pkg::FIELD_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_operation,
  input  logic [W-1:0] in_operand_a,
  input  logic [W-1:0] in_operand_b,
  output logic         q_valid,
  input  logic         q_pop,
  output pfa_pkg::op_t q_op,
  output logic [W-1:0] q_a,
  output logic [W-1:0] q_b
);

  localparam int EW = 2 + 2 * W;

  logic [EW-1:0] mem_r [pfa_pkg::QUEUE_DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic          pop;
  logic [EW-1:0] rd_data;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop & q_valid;
  assign rd_data  = mem_r[rd_ptr_r];
  assign q_op     = pfa_pkg::op_t'(rd_data[EW-1 -: 2]);
  assign q_a      = rd_data[2*W-1 -: W];
  assign q_b      = rd_data[W-1:0];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= {in_operation, in_operand_a, in_operand_b};
    end
  end

endmodule

// File: sv/pfa_core.sv
// Back end: sequential modular reduce, add, subtract, multiply and inverse engine.
`timescale 1ns / 1ps
module pfa_core #(
  parameter int W = pfa_pkg::FIELD_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] modulus,
  input  logic         q_valid,
  output logic         q_pop,
  input  pfa_pkg::op_t q_op,
  input  logic [W-1:0] q_a,
  input  logic [W-1:0] q_b,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_result,
  output logic         out_no_inverse
);

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_TOP = CW'(W - 1);

  pfa_pkg::state_t state_r, state_nxt;
  pfa_pkg::op_t    op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  raw_a_r, raw_a_nxt, raw_b_r, raw_b_nxt;
  logic [W-1:0]  xa_r, xa_nxt, xb_r, xb_nxt, acc_r, acc_nxt;
  logic [W-1:0]  r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [W-1:0]  rem_r, rem_nxt, qt_r, qt_nxt;
  logic          qb_r, qb_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          flag_r, flag_nxt;
  logic          m_small;
  logic [W:0]    shf;

  function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mod_sub(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    return (x >= y) ? (x - y) : (x + (m - y));
  endfunction

  function automatic logic [W-1:0] red_step(input logic [W-1:0] r, input logic bit_in,
                                            input logic [W-1:0] m);
    logic [W:0] s;
    s = {r, bit_in};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  assign m_small        = (modulus < W'(2));
  assign q_pop          = (state_r == pfa_pkg::ST_IDLE);
  assign out_valid      = (state_r == pfa_pkg::ST_OUT);
  assign out_result     = res_r;
  assign out_no_inverse = flag_r;
  assign shf            = {rem_r, r0_r[cnt_r]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfa_pkg::ST_IDLE: begin
        if (q_valid) state_nxt = m_small ? pfa_pkg::ST_OUT : pfa_pkg::ST_RED;
      end
      pfa_pkg::ST_RED: begin
        if (cnt_r == '0) state_nxt = pfa_pkg::ST_DISP;
      end
      pfa_pkg::ST_DISP: begin
        case (op_r)
          pfa_pkg::OP_MUL: state_nxt = pfa_pkg::ST_MUL_DBL;
          pfa_pkg::OP_DIV: state_nxt = pfa_pkg::ST_EU_CHK;
          default:         state_nxt = pfa_pkg::ST_OUT;
        endcase
      end
      pfa_pkg::ST_MUL_DBL: state_nxt = pfa_pkg::ST_MUL_ADD;
      pfa_pkg::ST_MUL_ADD: begin
        state_nxt = (cnt_r == '0) ? pfa_pkg::ST_OUT : pfa_pkg::ST_MUL_DBL;
      end
      pfa_pkg::ST_EU_CHK: begin
        if (r1_r == '0) begin
          state_nxt = (r0_r == W'(1)) ? pfa_pkg::ST_MUL_DBL : pfa_pkg::ST_OUT;
        end else begin
          state_nxt = pfa_pkg::ST_DIV_SHF;
        end
      end
      pfa_pkg::ST_DIV_SHF: state_nxt = pfa_pkg::ST_DIV_ACC;
      pfa_pkg::ST_DIV_ACC: begin
        state_nxt = (cnt_r == '0) ? pfa_pkg::ST_EU_UPD : pfa_pkg::ST_DIV_SHF;
      end
      pfa_pkg::ST_EU_UPD: state_nxt = pfa_pkg::ST_EU_CHK;
      pfa_pkg::ST_OUT: begin
        if (!out_stall) state_nxt = pfa_pkg::ST_IDLE;
      end
      default: state_nxt = pfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    raw_a_nxt = raw_a_r;
    raw_b_nxt = raw_b_r;
    xa_nxt    = xa_r;
    xb_nxt    = xb_r;
    acc_nxt   = acc_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    rem_nxt   = rem_r;
    qt_nxt    = qt_r;
    qb_nxt    = qb_r;
    res_nxt   = res_r;
    flag_nxt  = flag_r;
    case (state_r)
      pfa_pkg::ST_IDLE: begin
        op_nxt    = q_op;
        raw_a_nxt = q_a;
        raw_b_nxt = q_b;
        xa_nxt    = '0;
        xb_nxt    = '0;
        cnt_nxt   = CNT_TOP;
        res_nxt   = '0;
        flag_nxt  = (q_op == pfa_pkg::OP_DIV);
      end
      pfa_pkg::ST_RED: begin
        xa_nxt = red_step(xa_r, raw_a_r[cnt_r], modulus);
        xb_nxt = red_step(xb_r, raw_b_r[cnt_r], modulus);
        cnt_nxt = cnt_r - 1'b1;
      end
      pfa_pkg::ST_DISP: begin
        flag_nxt = 1'b0;
        cnt_nxt  = CNT_TOP;
        acc_nxt  = '0;
        r0_nxt   = modulus;
        r1_nxt   = xb_r;
        t0_nxt   = '0;
        t1_nxt   = W'(1);
        case (op_r)
          pfa_pkg::OP_ADD: res_nxt = mod_add(xa_r, xb_r, modulus);
          pfa_pkg::OP_SUB: res_nxt = mod_sub(xa_r, xb_r, modulus);
          default:         res_nxt = res_r;
        endcase
      end
      pfa_pkg::ST_MUL_DBL: acc_nxt = mod_add(acc_r, acc_r, modulus);
      pfa_pkg::ST_MUL_ADD: begin
        if (xb_r[cnt_r]) acc_nxt = mod_add(acc_r, xa_r, modulus);
        res_nxt = xb_r[cnt_r] ? mod_add(acc_r, xa_r, modulus) : acc_r;
        cnt_nxt = cnt_r - 1'b1;
      end
      pfa_pkg::ST_EU_CHK: begin
        cnt_nxt = CNT_TOP;
        rem_nxt = '0;
        qt_nxt  = '0;
        acc_nxt = '0;
        if (r1_r == '0) begin
          xb_nxt = t0_r;
          if (r0_r != W'(1)) begin
            res_nxt  = '0;
            flag_nxt = 1'b1;
          end
        end
      end
      pfa_pkg::ST_DIV_SHF: begin
        if (shf >= {1'b0, r1_r}) begin
          rem_nxt = W'(shf - {1'b0, r1_r});
          qb_nxt  = 1'b1;
        end else begin
          rem_nxt = shf[W-1:0];
          qb_nxt  = 1'b0;
        end
        qt_nxt = mod_add(qt_r, qt_r, modulus);
      end
      pfa_pkg::ST_DIV_ACC: begin
        if (qb_r) qt_nxt = mod_add(qt_r, t1_r, modulus);
        cnt_nxt = cnt_r - 1'b1;
      end
      pfa_pkg::ST_EU_UPD: begin
        r0_nxt = r1_r;
        r1_nxt = rem_r;
        t0_nxt = t1_r;
        t1_nxt = mod_sub(t0_r, qt_r, modulus);
      end
      default: begin
        op_nxt = op_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    cnt_r   <= cnt_nxt;
    raw_a_r <= raw_a_nxt;
    raw_b_r <= raw_b_nxt;
    xa_r    <= xa_nxt;
    xb_r    <= xb_nxt;
    acc_r   <= acc_nxt;
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    rem_r   <= rem_nxt;
    qt_r    <= qt_nxt;
    qb_r    <= qb_nxt;
    res_r   <= res_nxt;
    flag_r  <= flag_nxt;
  end

endmodule

// File: sv/prime_field_alu_top.sv
// Top level of the prime field arithmetic unit: modulus register, queue and core.
//
// Input channel in_*: one beat carries an operation (add, subtract, multiply,
// divide) and two operands; it is taken when in_valid is high and in_stall low.
// Output channel out_*: one beat per input beat, in order, holding the result
// below the modulus and the no_inverse flag; taken when out_valid is high and
// out_stall low. The result stays on the port while out_stall is high.
// cfg_*: writes the modulus; cfg_ready is always high. Write only while idle.
// A two-beat queue takes input while the core works on an earlier beat.
// Core work per beat (W = FIELD_WIDTH): both operands are reduced in
// parallel, one bit a cycle over W bits. Add and subtract then finish in the
// dispatch state; multiply does a double, then a conditional add, per
// multiplier bit. Divide runs extended Euclid to invert b (bit-serial quotient
// with q*t folded in per remainder step), then multiplies a by the inverse.
// The core pops a beat from the queue while idle and presents results in ST_OUT.
// A modulus below two gives result zero without reducing the operands.
// Reset (rst_n low, synchronous) empties the queue, idles the core and
// loads modulus 1071482619497.
`timescale 1ns / 1ps
module prime_field_alu_top #(
  parameter int FIELD_WIDTH = pfa_pkg::FIELD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_operation,
  input  logic [FIELD_WIDTH-1:0] in_operand_a,
  input  logic [FIELD_WIDTH-1:0] in_operand_b,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FIELD_WIDTH-1:0] out_result,
  output logic                   out_no_inverse,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [FIELD_WIDTH-1:0] cfg_modulus
);

  localparam logic [FIELD_WIDTH-1:0] MOD_RST = FIELD_WIDTH'(pfa_pkg::MODULUS_RESET);

  logic [FIELD_WIDTH-1:0] modulus_r, modulus_nxt;
  logic                   q_valid;
  logic                   q_pop;
  pfa_pkg::op_t           q_op;
  logic [FIELD_WIDTH-1:0] q_a;
  logic [FIELD_WIDTH-1:0] q_b;

  assign cfg_ready   = 1'b1;
  assign modulus_nxt = (cfg_valid & cfg_ready) ? cfg_modulus : modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RST;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  pfa_queue #(.W(FIELD_WIDTH)) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_op         (q_op),
    .q_a          (q_a),
    .q_b          (q_b)
  );

  pfa_core #(.W(FIELD_WIDTH)) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .modulus        (modulus_r),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_op           (q_op),
    .q_a            (q_a),
    .q_b            (q_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result     (out_result),
    .out_no_inverse (out_no_inverse)
  );

endmodule
